/* sv/ctrb_pkg.sv */
// ----------------------------------------------------------------------------
// ctrb_pkg
// shared constants, types and elaboration-time helpers of the kelvin to rgb
// converter
// ----------------------------------------------------------------------------
package ctrb_pkg;

  localparam int FRAC_BITS_DEF = 16;

  localparam int KW     = 16;
  localparam int CW     = 8;
  localparam int INT_W  = 9;
  localparam int EXP_W  = 4;

  localparam logic [KW-1:0] K_MIN      = 16'd1000;
  localparam logic [KW-1:0] K_MAX      = 16'd40000;
  localparam logic [KW-1:0] K_SIXTY    = 16'd6000;
  localparam logic [KW-1:0] K_SIXTYSIX = 16'd6600;
  localparam logic [KW-1:0] K_NINETEEN = 16'd1900;
  localparam logic [KW-1:0] K_TEN      = 16'd1000;

  localparam logic [CW-1:0] CH_MAX = 8'd255;

  localparam longint unsigned DEC_SCALE = 64'd1000000000;

  localparam longint unsigned C_RED_GAIN    = 64'd329698727446;
  localparam longint unsigned C_RED_EXP     = 64'd133204759;
  localparam longint unsigned C_GRN_LO_GAIN = 64'd99470802586;
  localparam longint unsigned C_GRN_LO_OFS  = 64'd161119568166;
  localparam longint unsigned C_GRN_HI_GAIN = 64'd288122169528;
  localparam longint unsigned C_GRN_HI_EXP  = 64'd75514849;
  localparam longint unsigned C_BLU_GAIN    = 64'd138517731223;
  localparam longint unsigned C_BLU_OFS     = 64'd305044792731;
  localparam longint unsigned C_LN2         = 64'd693147181;

  // floor(w/100) as (w*DIV100_MUL)>>DIV100_SHIFT, exact for w below 2^23
  localparam int            DIV100_W     = 23;
  localparam int            DIV100_MW    = 24;
  localparam int            DIV100_SHIFT = 30;
  localparam logic [23:0]   DIV100_MUL   = 24'd10737419;

  typedef struct packed {
    logic lo66;
    logic ge66;
    logic le19;
  } band_t;

  typedef struct packed {
    logic          lo66;
    logic [CW-1:0] green;
    logic [CW-1:0] blue;
  } lo_res_t;

  function automatic longint unsigned fx_const(longint unsigned n, int f);
    return (n << f) / DEC_SCALE;
  endfunction

  function automatic longint unsigned isqrt64(longint unsigned v);
    longint unsigned r;
    longint unsigned b;
    longint unsigned x;
    x = v;
    r = 0;
    b = 64'h4000_0000_0000_0000;
    for (int j = 0; j < 32; j++) begin
      if (x >= r + b) begin
        x = x - (r + b);
        r = (r >> 1) + b;
      end else begin
        r = r >> 1;
      end
      b = b >> 2;
    end
    return r;
  endfunction

  // 2^(2^-i) in q.f, by repeated truncated square roots
  function automatic longint unsigned exp_root(int i, int f);
    longint unsigned root;
    root = 64'd2 << f;
    for (int j = 1; j <= i; j++) begin
      root = isqrt64(root << f);
    end
    return root;
  endfunction

endpackage

/* sv/ctrb_if.sv */
// ----------------------------------------------------------------------------
// ctrb_in_if / ctrb_out_if
// valid/ready channels of the kelvin to rgb converter
// ----------------------------------------------------------------------------
interface ctrb_in_if import ctrb_pkg::*; ();
  logic          valid;
  logic          ready;
  logic [KW-1:0] kelvin;

  modport source (output valid, output kelvin, input ready);
  modport sink (input valid, input kelvin, output ready);
endinterface

interface ctrb_out_if import ctrb_pkg::*; ();
  logic          valid;
  logic          ready;
  logic [CW-1:0] red;
  logic [CW-1:0] green;
  logic [CW-1:0] blue;

  modport source (output valid, output red, output green, output blue, input ready);
  modport sink (input valid, input red, input green, input blue, output ready);
endinterface

/* sv/ctrb_delay.sv */
// ----------------------------------------------------------------------------
// ctrb_delay
// stallable delay line that keeps side data aligned with the main pipeline
// ----------------------------------------------------------------------------
module ctrb_delay #(
  parameter int W     = 8,
  parameter int DEPTH = 1
) (
  input  logic         clk,
  input  logic         en,
  input  logic [W-1:0] d,
  output logic [W-1:0] q
);

  logic [W-1:0] tap_r [DEPTH];

  always_ff @(posedge clk) begin
    if (en) begin
      tap_r[0] <= d;
      for (int j = 1; j < DEPTH; j++) begin
        tap_r[j] <= tap_r[j-1];
      end
    end
  end

  assign q = tap_r[DEPTH-1];

endmodule

/* sv/ctrb_log2.sv */
// ----------------------------------------------------------------------------
// ctrb_log2
// pipelined log2: leading-one normalize, then one squaring step per stage
// ----------------------------------------------------------------------------
module ctrb_log2 import ctrb_pkg::*; #(
  parameter int FB = FRAC_BITS_DEF
) (
  input  logic                  clk,
  input  logic                  rst_n,
  input  logic                  en,
  input  logic                  in_valid,
  input  logic [FB+INT_W-1:0]   x,
  output logic                  out_valid,
  output logic [FB+EXP_W-1:0]   log_val
);

  localparam int XW = FB + INT_W;
  localparam logic [FB:0] ONE = {1'b1, {FB{1'b0}}};

  logic [FB:0]       m_r    [FB+1];
  logic [FB-1:0]     frac_r [FB+1];
  logic [EXP_W-1:0]  e_r    [FB+1];
  logic              v_r    [FB+1];

  logic [EXP_W-1:0]  e0;
  logic [FB:0]       m0;
  logic [XW-1:0]     xs;

  always_comb begin
    e0 = '0;
    for (int j = 0; j < INT_W; j++) begin
      if (x[FB+j]) e0 = EXP_W'(j);
    end
    xs = x >> e0;
    if (x[XW-1:FB] != '0) begin
      m0 = xs[FB:0];
    end else begin
      m0 = ONE;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v_r[0] <= 1'b0;
    end else if (en) begin
      v_r[0] <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      m_r[0]    <= m0;
      e_r[0]    <= e0;
      frac_r[0] <= '0;
    end
  end

  for (genvar i = 1; i <= FB; i++) begin : g_step
    logic [2*FB+1:0] sq;
    logic [FB+1:0]   t;
    logic [FB:0]     m_n;
    logic [FB-1:0]   f_n;

    assign sq = (2*FB+2)'(m_r[i-1]) * (2*FB+2)'(m_r[i-1]);
    assign t  = sq[2*FB+1:FB];

    always_comb begin
      f_n = frac_r[i-1];
      if (t[FB+1]) begin
        m_n        = t[FB+1:1];
        f_n[FB-i]  = 1'b1;
      end else begin
        m_n = t[FB:0];
      end
    end

    always_ff @(posedge clk) begin
      if (!rst_n) begin
        v_r[i] <= 1'b0;
      end else if (en) begin
        v_r[i] <= v_r[i-1];
      end
    end

    always_ff @(posedge clk) begin
      if (en) begin
        m_r[i]    <= m_n;
        e_r[i]    <= e_r[i-1];
        frac_r[i] <= f_n;
      end
    end
  end

  assign out_valid = v_r[FB];
  assign log_val   = {e_r[FB], frac_r[FB]};

endmodule

/* sv/ctrb_exp2.sv */
// ----------------------------------------------------------------------------
// ctrb_exp2
// pipelined 2^frac: one root-of-two product per fraction bit and stage
// ----------------------------------------------------------------------------
module ctrb_exp2 import ctrb_pkg::*; #(
  parameter int FB = FRAC_BITS_DEF
) (
  input  logic                 clk,
  input  logic                 rst_n,
  input  logic                 en,
  input  logic                 in_valid,
  input  logic [FB+EXP_W-1:0]  y,
  output logic                 out_valid,
  output logic [FB:0]          res,
  output logic [EXP_W-1:0]     n
);

  localparam int YW = FB + EXP_W;
  localparam logic [FB:0] ONE = {1'b1, {FB{1'b0}}};

  logic [FB:0]   res_r [1:FB];
  logic [YW-1:0] y_r   [1:FB];
  logic          v_r   [1:FB];

  for (genvar i = 1; i <= FB; i++) begin : g_step
    localparam logic [FB:0] ROOT = (FB+1)'(exp_root(i, FB));

    logic [FB:0]     res_p;
    logic [YW-1:0]   y_p;
    logic            v_p;
    logic [2*FB+1:0] prod;
    logic [FB:0]     res_n;

    if (i == 1) begin : g_first
      assign res_p = ONE;
      assign y_p   = y;
      assign v_p   = in_valid;
    end else begin : g_next
      assign res_p = res_r[i-1];
      assign y_p   = y_r[i-1];
      assign v_p   = v_r[i-1];
    end

    assign prod  = (2*FB+2)'(res_p) * (2*FB+2)'(ROOT);
    assign res_n = y_p[FB-i] ? prod[2*FB:FB] : res_p;

    always_ff @(posedge clk) begin
      if (!rst_n) begin
        v_r[i] <= 1'b0;
      end else if (en) begin
        v_r[i] <= v_p;
      end
    end

    always_ff @(posedge clk) begin
      if (en) begin
        res_r[i] <= res_n;
        y_r[i]   <= y_p;
      end
    end
  end

  // integer part stays below 16 for any 4-bit exponent, so no doubling cap
  assign out_valid = v_r[FB];
  assign res       = res_r[FB];
  assign n         = y_r[FB][YW-1:FB];

endmodule

/* sv/ctrb_recip.sv */
// ----------------------------------------------------------------------------
// ctrb_recip
// pipelined restoring divider for 2^(2f)/d, one quotient bit per stage,
// then a right shift by the integer power
// ----------------------------------------------------------------------------
module ctrb_recip import ctrb_pkg::*; #(
  parameter int FB = FRAC_BITS_DEF
) (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              en,
  input  logic              in_valid,
  input  logic [FB:0]       d,
  input  logic [EXP_W-1:0]  n,
  output logic              out_valid,
  output logic [FB:0]       q
);

  localparam logic [FB:0] R0 = (FB+1)'(1) << (FB-1);

  logic [FB:0]      r_r [FB+1];
  logic [FB:0]      q_r [FB+1];
  logic [FB:0]      d_r [FB+1];
  logic [EXP_W-1:0] n_r [FB+1];
  logic             v_r [FB+1];
  logic [FB:0]      qo_r;
  logic             vo_r;

  for (genvar k = 0; k <= FB; k++) begin : g_step
    logic [FB:0]      r_p;
    logic [FB:0]      q_p;
    logic [FB:0]      d_p;
    logic [EXP_W-1:0] n_p;
    logic             v_p;
    logic [FB+1:0]    t;
    logic [FB+1:0]    diff;
    logic             ge;

    if (k == 0) begin : g_first
      assign r_p = R0;
      assign q_p = '0;
      assign d_p = d;
      assign n_p = n;
      assign v_p = in_valid;
    end else begin : g_next
      assign r_p = r_r[k-1];
      assign q_p = q_r[k-1];
      assign d_p = d_r[k-1];
      assign n_p = n_r[k-1];
      assign v_p = v_r[k-1];
    end

    assign t    = {r_p, 1'b0};
    assign diff = t - {1'b0, d_p};
    assign ge   = (t >= {1'b0, d_p});

    always_ff @(posedge clk) begin
      if (!rst_n) begin
        v_r[k] <= 1'b0;
      end else if (en) begin
        v_r[k] <= v_p;
      end
    end

    always_ff @(posedge clk) begin
      if (en) begin
        r_r[k] <= ge ? diff[FB:0] : t[FB:0];
        q_r[k] <= {q_p[FB-1:0], ge};
        d_r[k] <= d_p;
        n_r[k] <= n_p;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vo_r <= 1'b0;
    end else if (en) begin
      vo_r <= v_r[FB];
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      qo_r <= q_r[FB] >> n_r[FB];
    end
  end

  assign out_valid = vo_r;
  assign q         = qo_r;

endmodule

/* sv/color_temperature_to_rgb_top.sv */
// ----------------------------------------------------------------------------
// color_temperature_to_rgb_top
// kelvin to 8-bit rgb by the piecewise log/power fit, fully pipelined
// ----------------------------------------------------------------------------
// in_ch carries one kelvin value per beat; kelvin is saturated to 1000..40000.
// out_ch carries red, green and blue for that value, in order, one beat per
// input beat.
// a beat can be accepted in every cycle while the output is not stalled;
// throughput is then one conversion per clock. the path from accept to
// out_ch.valid runs through the log2 squaring chain, the exp2 product chain
// and the bit-per-stage reciprocal divider of the power-law path.
// rst_n (synchronous, active low) clears all valid bits; beats in flight are
// dropped and no state survives.
// when out_ch.ready is low with a beat waiting, the whole pipeline holds and
// in_ch.ready drops in the same cycle; nothing is lost or repeated.
// ----------------------------------------------------------------------------
module color_temperature_to_rgb_top import ctrb_pkg::*; #(
  parameter int FRAC_BITS = FRAC_BITS_DEF
) (
  input  logic              clk,
  input  logic              rst_n,
  ctrb_in_if.sink           in_ch,
  ctrb_out_if.source        out_ch
);

  localparam int FB  = FRAC_BITS;
  localparam int XW  = FB + INT_W;
  localparam int LW  = FB + EXP_W;
  localparam int GW  = FB + 9;
  localparam int PW  = FB + KW;
  localparam int TW  = DIV100_W + DIV100_MW - DIV100_SHIFT;
  localparam int SLW = FB + 13;
  localparam int SHW = FB + 10;

  localparam logic [FB-1:0] Q100 = FB'((64'd1 << FB) / 100);
  localparam logic [6:0]    R100 = 7'((64'd1 << FB) % 100);

  localparam logic [FB-1:0] LN2_Q        = FB'(fx_const(C_LN2, FB));
  localparam logic [FB-1:0] RED_EXP_Q    = FB'(fx_const(C_RED_EXP, FB));
  localparam logic [FB-1:0] GRN_HI_EXP_Q = FB'(fx_const(C_GRN_HI_EXP, FB));
  localparam logic [GW-1:0] RED_GAIN_Q   = GW'(fx_const(C_RED_GAIN, FB));
  localparam logic [GW-1:0] GRN_HI_GAIN_Q = GW'(fx_const(C_GRN_HI_GAIN, FB));
  localparam logic [GW-1:0] GRN_LO_GAIN_Q = GW'(fx_const(C_GRN_LO_GAIN, FB));
  localparam logic [GW-1:0] GRN_LO_OFS_Q = GW'(fx_const(C_GRN_LO_OFS, FB));
  localparam logic [GW-1:0] BLU_GAIN_Q   = GW'(fx_const(C_BLU_GAIN, FB));
  localparam logic [GW-1:0] BLU_OFS_Q    = GW'(fx_const(C_BLU_OFS, FB));

  localparam int LO_DLY = 2 * FB + 2;
  localparam int WMW    = DIV100_W + DIV100_MW;
  localparam int LNW    = 2 * FB + EXP_W;
  localparam int RPW    = GW + FB + 1;

  logic en;
  logic out_valid_r;

  assign en          = !out_valid_r || out_ch.ready;
  assign in_ch.ready = en;

  // stage 1: saturate and pick operands
  logic [KW-1:0] k_sat;
  band_t         band1;
  logic [KW-1:0] da1_r, db1_r;
  band_t         band1_r;
  logic          v1_r;

  always_comb begin
    if (in_ch.kelvin < K_MIN) begin
      k_sat = K_MIN;
    end else if (in_ch.kelvin > K_MAX) begin
      k_sat = K_MAX;
    end else begin
      k_sat = in_ch.kelvin;
    end
    band1.lo66 = (k_sat <= K_SIXTYSIX);
    band1.ge66 = (k_sat >= K_SIXTYSIX);
    band1.le19 = (k_sat <= K_NINETEEN);
  end

  always_ff @(posedge clk) begin
    if (en) begin
      da1_r   <= band1.lo66 ? k_sat : k_sat - K_SIXTY;
      db1_r   <= k_sat - K_TEN;
      band1_r <= band1;
    end
  end

  // stages 2..4: x = d*2^f/100 as d*q100 + floor(d*r100/100)
  logic [PW-1:0]       pa2_r, pb2_r, pa3_r, pb3_r;
  logic [DIV100_W-1:0] wa2_r, wb2_r;
  logic [TW-1:0]       ta3_r, tb3_r;
  logic [DIV100_W+DIV100_MW-1:0] wma, wmb;
  logic [PW-1:0]       suma, sumb;
  logic [XW-1:0]       xa4_r, xb4_r;
  band_t               band2_r, band3_r, band4_r;
  logic                v2_r, v3_r, v4_r;

  assign wma  = WMW'(wa2_r) * WMW'(DIV100_MUL);
  assign wmb  = WMW'(wb2_r) * WMW'(DIV100_MUL);
  assign suma = pa3_r + PW'(ta3_r);
  assign sumb = pb3_r + PW'(tb3_r);

  always_ff @(posedge clk) begin
    if (en) begin
      pa2_r   <= PW'(da1_r) * PW'(Q100);
      pb2_r   <= PW'(db1_r) * PW'(Q100);
      wa2_r   <= DIV100_W'(da1_r) * DIV100_W'(R100);
      wb2_r   <= DIV100_W'(db1_r) * DIV100_W'(R100);
      band2_r <= band1_r;
      pa3_r   <= pa2_r;
      pb3_r   <= pb2_r;
      ta3_r   <= wma[DIV100_W+DIV100_MW-1:DIV100_SHIFT];
      tb3_r   <= wmb[DIV100_W+DIV100_MW-1:DIV100_SHIFT];
      band3_r <= band2_r;
      xa4_r   <= suma[XW-1:0];
      xb4_r   <= sumb[XW-1:0];
      band4_r <= band3_r;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v1_r <= 1'b0;
      v2_r <= 1'b0;
      v3_r <= 1'b0;
      v4_r <= 1'b0;
    end else if (en) begin
      v1_r <= in_ch.valid;
      v2_r <= v1_r;
      v3_r <= v2_r;
      v4_r <= v3_r;
    end
  end

  // log2 of both operands
  logic [LW-1:0] loga, logb;
  logic          vla, vlb;
  band_t         band_l;

  ctrb_log2 #(.FB(FB)) u_log_a (
    .clk(clk), .rst_n(rst_n), .en(en), .in_valid(v4_r), .x(xa4_r),
    .out_valid(vla), .log_val(loga)
  );

  ctrb_log2 #(.FB(FB)) u_log_b (
    .clk(clk), .rst_n(rst_n), .en(en), .in_valid(v4_r), .x(xb4_r),
    .out_valid(vlb), .log_val(logb)
  );

  ctrb_delay #(.W($bits(band_t)), .DEPTH(FB + 1)) u_band_dly (
    .clk(clk), .en(en), .d(band4_r), .q(band_l)
  );

  // log branch: green at or below 6600 k and blue
  logic [2*FB+EXP_W-1:0] lnpa, lnpb;
  logic [LW-1:0]         lna1_r, lnb1_r;
  band_t                 bandl1_r, bandl2_r;
  logic [GW+LW-1:0]      gpa, gpb;
  logic [SLW-1:0]        sa2_r, sb2_r;
  logic [SLW-1:0]        gdiff, bdiff;
  logic [SLW-FB-1:0]     gint, bint;
  logic [CW-1:0]         gl, bl;
  lo_res_t               lo_res_r, lo_res_d;

  assign lnpa = LNW'(loga) * LNW'(LN2_Q);
  assign lnpb = LNW'(logb) * LNW'(LN2_Q);
  assign gpa  = (GW+LW)'(GRN_LO_GAIN_Q) * (GW+LW)'(lna1_r);
  assign gpb  = (GW+LW)'(BLU_GAIN_Q) * (GW+LW)'(lnb1_r);

  always_comb begin
    gdiff = sa2_r - SLW'(GRN_LO_OFS_Q);
    bdiff = sb2_r - SLW'(BLU_OFS_Q);
    gint  = gdiff[SLW-1:FB];
    bint  = bdiff[SLW-1:FB];
    if (sa2_r < SLW'(GRN_LO_OFS_Q)) begin
      gl = '0;
    end else if (gint > (SLW-FB)'(CH_MAX)) begin
      gl = CH_MAX;
    end else begin
      gl = gint[CW-1:0];
    end
    if (bandl2_r.ge66) begin
      bl = CH_MAX;
    end else if (bandl2_r.le19 || (sb2_r < SLW'(BLU_OFS_Q))) begin
      bl = '0;
    end else if (bint > (SLW-FB)'(CH_MAX)) begin
      bl = CH_MAX;
    end else begin
      bl = bint[CW-1:0];
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      lna1_r         <= lnpa[2*FB+EXP_W-1:FB];
      lnb1_r         <= lnpb[2*FB+EXP_W-1:FB];
      bandl1_r       <= band_l;
      sa2_r          <= gpa[GW+LW-1:FB];
      sb2_r          <= gpb[GW+LW-1:FB];
      bandl2_r       <= bandl1_r;
      lo_res_r.lo66  <= bandl2_r.lo66;
      lo_res_r.green <= gl;
      lo_res_r.blue  <= bl;
    end
  end

  ctrb_delay #(.W($bits(lo_res_t)), .DEPTH(LO_DLY)) u_lo_dly (
    .clk(clk), .en(en), .d(lo_res_r), .q(lo_res_d)
  );

  // power branch: red and green above 6600 k
  logic [2*FB+EXP_W-1:0] ypr, ypg;
  logic [LW-1:0]         yr1_r, yg1_r;
  logic                  vh1_r;
  logic [FB:0]           er, eg;
  logic [EXP_W-1:0]      nr, ng;
  logic                  ver, veg;
  logic [FB:0]           qr, qg;
  logic                  vrr, vrg;
  logic [GW+FB:0]        rp, gp;
  logic [SHW-1:0]        sr2_r, sg2_r;
  logic                  vh2_r;
  logic [SHW-FB-1:0]     rint, gint_h;
  logic [CW-1:0]         rh3_r, gh3_r;
  logic                  vh3_r;

  assign ypr    = LNW'(RED_EXP_Q) * LNW'(loga);
  assign ypg    = LNW'(GRN_HI_EXP_Q) * LNW'(loga);
  assign rp     = RPW'(RED_GAIN_Q) * RPW'(qr);
  assign gp     = RPW'(GRN_HI_GAIN_Q) * RPW'(qg);
  assign rint   = sr2_r[SHW-1:FB];
  assign gint_h = sg2_r[SHW-1:FB];

  always_ff @(posedge clk) begin
    if (en) begin
      yr1_r <= ypr[2*FB+EXP_W-1:FB];
      yg1_r <= ypg[2*FB+EXP_W-1:FB];
      sr2_r <= rp[GW+FB:FB];
      sg2_r <= gp[GW+FB:FB];
      rh3_r <= (rint > (SHW-FB)'(CH_MAX)) ? CH_MAX : rint[CW-1:0];
      gh3_r <= (gint_h > (SHW-FB)'(CH_MAX)) ? CH_MAX : gint_h[CW-1:0];
    end
  end

  ctrb_exp2 #(.FB(FB)) u_exp_r (
    .clk(clk), .rst_n(rst_n), .en(en), .in_valid(vh1_r), .y(yr1_r),
    .out_valid(ver), .res(er), .n(nr)
  );

  ctrb_exp2 #(.FB(FB)) u_exp_g (
    .clk(clk), .rst_n(rst_n), .en(en), .in_valid(vh1_r), .y(yg1_r),
    .out_valid(veg), .res(eg), .n(ng)
  );

  ctrb_recip #(.FB(FB)) u_rcp_r (
    .clk(clk), .rst_n(rst_n), .en(en), .in_valid(ver), .d(er), .n(nr),
    .out_valid(vrr), .q(qr)
  );

  ctrb_recip #(.FB(FB)) u_rcp_g (
    .clk(clk), .rst_n(rst_n), .en(en), .in_valid(veg), .d(eg), .n(ng),
    .out_valid(vrg), .q(qg)
  );

  // output register
  logic [CW-1:0] red_r, green_r, blue_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vh1_r       <= 1'b0;
      vh2_r       <= 1'b0;
      vh3_r       <= 1'b0;
      out_valid_r <= 1'b0;
    end else if (en) begin
      vh1_r       <= vla;
      vh2_r       <= vrr;
      vh3_r       <= vh2_r;
      out_valid_r <= vh3_r;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      red_r   <= lo_res_d.lo66 ? CH_MAX : rh3_r;
      green_r <= lo_res_d.lo66 ? lo_res_d.green : gh3_r;
      blue_r  <= lo_res_d.blue;
    end
  end

  assign out_ch.valid = out_valid_r;
  assign out_ch.red   = red_r;
  assign out_ch.green = green_r;
  assign out_ch.blue  = blue_r;

`ifndef SYNTHESIS
  a_log_align: assert property (@(posedge clk) disable iff (!rst_n) vla == vlb)
    else $error("log units out of step");
  a_exp_align: assert property (@(posedge clk) disable iff (!rst_n) ver == veg)
    else $error("exp2 units out of step");
  a_rcp_align: assert property (@(posedge clk) disable iff (!rst_n) vrr == vrg)
    else $error("reciprocal units out of step");
  a_stall_hold: assert property (@(posedge clk) disable iff (!rst_n)
    (!en && vh3_r) |=> vh3_r)
    else $error("pipeline beat lost during stall");
`endif

endmodule

/* bench/tb_top.sv */
// ----------------------------------------------------------------------------
// tb_top
// bench for the kelvin to rgb converter: random and directed kelvin beats are
// driven with bursts of idling on both channels, and every output beat is
// compared with a fixed point prediction of the piecewise log/power fit
// ----------------------------------------------------------------------------
module tb_top;
  timeunit 1ns;
  timeprecision 1ps;
  import ctrb_pkg::*;

  localparam int F = FRAC_BITS_DEF;
  localparam longint unsigned ONE = 64'd1 << F;
  localparam int LATENCY = 3 * F + 10;
  localparam int N_RANDOM = 700;
  localparam longint LIMIT = 200000;

  typedef struct packed {
    logic [CW-1:0] red;
    logic [CW-1:0] green;
    logic [CW-1:0] blue;
  } rgb_t;

  logic clk = 1'b0;
  logic rst_n = 1'b0;
  always #6 clk = ~clk;

  ctrb_in_if  in_ch ();
  ctrb_out_if out_ch ();

  color_temperature_to_rgb_top dut (
    .clk   (clk),
    .rst_n (rst_n),
    .in_ch (in_ch.sink),
    .out_ch(out_ch.source)
  );

  logic [KW-1:0] kelvin_q[$];
  rgb_t          rgb_expected_q[$];
  int            errors = 0;
  bit            stim_done = 1'b0;
  bit            quiet = 1'b0;
  bit            hold_in = 1'b0;
  int            in_gap = 0;
  int            out_gap = 0;
  longint        cycles = 0;

  function automatic longint unsigned qconst(longint unsigned n);
    return (n << F) / DEC_SCALE;
  endfunction

  function automatic longint unsigned q_kelvin(int unsigned k, int unsigned base);
    return (longint'(k - base) << F) / 100;
  endfunction

  function automatic longint unsigned sqrt_floor(longint unsigned v);
    longint unsigned r, b, x;
    x = v;
    r = 0;
    b = 64'd1 << 62;
    while (b > x && b != 0) b = b >> 2;
    while (b != 0) begin
      if (x >= r + b) begin
        x = x - (r + b);
        r = (r >> 1) + b;
      end else begin
        r = r >> 1;
      end
      b = b >> 2;
    end
    return r;
  endfunction

  function automatic longint unsigned q_log2(longint unsigned x);
    int p;
    longint unsigned m, fr;
    fr = 0;
    if (x < ONE) return 0;
    p = 63;
    while (x[p] == 1'b0) p--;
    m = x >> (p - F);
    for (int i = 1; i <= F; i++) begin
      m = (m * m) >> F;
      if (m >= 2 * ONE) begin
        m = m >> 1;
        fr |= 64'd1 << (F - i);
      end
    end
    return (longint'(p - F) << F) | fr;
  endfunction

  function automatic longint unsigned q_ln(longint unsigned x);
    return (q_log2(x) * qconst(C_LN2)) >> F;
  endfunction

  function automatic longint unsigned q_exp2(longint unsigned y);
    longint unsigned n, res, root;
    n = y >> F;
    res = ONE;
    root = 2 * ONE;
    if (n > 16) n = 16;
    for (int i = 1; i <= F; i++) begin
      root = sqrt_floor(root << F);
      if ((y >> (F - i)) & 1) res = (res * root) >> F;
    end
    return res << n;
  endfunction

  function automatic longint unsigned q_neg_pow(longint unsigned x, longint unsigned e);
    longint unsigned y;
    y = (qconst(e) * q_log2(x)) >> F;
    return (ONE << F) / q_exp2(y);
  endfunction

  function automatic logic [CW-1:0] clamp_channel(longint v);
    longint unsigned i;
    if (v < 0) return 8'd0;
    i = longint'(v) >>> F;
    return (i > 255) ? 8'd255 : i[7:0];
  endfunction

  function automatic longint unsigned gained(longint unsigned g, longint unsigned term);
    return (qconst(g) * term) >> F;
  endfunction

  function automatic rgb_t kelvin_to_rgb(logic [KW-1:0] kin);
    int unsigned k;
    longint unsigned x;
    rgb_t c;
    k = kin;
    if (k < K_MIN) k = K_MIN;
    if (k > K_MAX) k = K_MAX;
    if (k <= K_SIXTYSIX) begin
      c.red = 8'd255;
      c.green = clamp_channel(longint'(gained(C_GRN_LO_GAIN, q_ln(q_kelvin(k, 0))))
                              - longint'(qconst(C_GRN_LO_OFS)));
    end else begin
      x = q_kelvin(k, K_SIXTY);
      c.red = clamp_channel(longint'(gained(C_RED_GAIN, q_neg_pow(x, C_RED_EXP))));
      c.green = clamp_channel(longint'(gained(C_GRN_HI_GAIN, q_neg_pow(x, C_GRN_HI_EXP))));
    end
    if (k >= K_SIXTYSIX) c.blue = 8'd255;
    else if (k <= K_NINETEEN) c.blue = 8'd0;
    else c.blue = clamp_channel(longint'(gained(C_BLU_GAIN, q_ln(q_kelvin(k, K_TEN))))
                                - longint'(qconst(C_BLU_OFS)));
    return c;
  endfunction

  // driver
  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (!rst_n) begin
      in_ch.valid <= 1'b0;
      in_ch.kelvin <= '0;
      in_gap <= 0;
    end else if (!in_ch.valid || in_ch.ready) begin
      if (in_ch.valid) rgb_expected_q.push_back(kelvin_to_rgb(in_ch.kelvin));
      if (in_gap > 0) begin
        in_gap <= in_gap - 1;
        in_ch.valid <= 1'b0;
      end else if (kelvin_q.size() > 0 && !hold_in) begin
        in_ch.valid <= 1'b1;
        in_ch.kelvin <= kelvin_q.pop_front();
        if (!quiet && $urandom_range(0, 9) == 0) in_gap <= $urandom_range(1, 7);
      end else begin
        in_ch.valid <= 1'b0;
      end
    end
  end

  // monitor
  always @(posedge clk) begin
    rgb_t want;
    if (!rst_n) begin
      out_ch.ready <= 1'b0;
      out_gap <= 0;
    end else begin
      if (out_ch.valid && out_ch.ready) begin
        if (rgb_expected_q.size() == 0) begin
          $error("unexpected beat r=%0d g=%0d b=%0d", out_ch.red, out_ch.green, out_ch.blue);
          errors++;
        end else begin
          want = rgb_expected_q.pop_front();
          if (out_ch.red !== want.red) begin
            $error("red expected %0d actual %0d", want.red, out_ch.red);
            errors++;
          end
          if (out_ch.green !== want.green) begin
            $error("green expected %0d actual %0d", want.green, out_ch.green);
            errors++;
          end
          if (out_ch.blue !== want.blue) begin
            $error("blue expected %0d actual %0d", want.blue, out_ch.blue);
            errors++;
          end
        end
      end
      if (out_gap > 0) begin
        out_gap <= out_gap - 1;
        out_ch.ready <= 1'b0;
      end else if (!quiet && $urandom_range(0, 11) == 0) begin
        out_gap <= $urandom_range(0, 6);
        out_ch.ready <= 1'b0;
      end else begin
        out_ch.ready <= 1'b1;
      end
    end
  end

  function automatic bit pipe_empty();
    return kelvin_q.size() == 0 && !in_ch.valid && rgb_expected_q.size() == 0;
  endfunction

  initial begin
    logic [KW-1:0] k;
    kelvin_q = '{16'd0, 16'd1, 16'd999, K_MIN, 16'd1001, 16'd1899, K_NINETEEN, 16'd1901,
                 16'd4000, 16'd6599, K_SIXTYSIX, 16'd6601, 16'd6700, 16'd10000,
                 16'd39999, K_MAX, 16'd40001, 16'hFFFF, 16'h8000, 16'h5555, 16'hAAAA};
    repeat (6) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);
    while (!pipe_empty()) @(posedge clk);
    // sender holds off until the pipeline has drained
    hold_in = 1'b1;
    repeat (LATENCY + 20) @(posedge clk);
    hold_in = 1'b0;
    for (int i = 0; i < N_RANDOM; i++) begin
      case ($urandom_range(0, 9))
        0: k = KW'($urandom());
        1: k = KW'($urandom_range(0, 1100));
        2: k = KW'($urandom_range(1800, 2000));
        3: k = KW'($urandom_range(6500, 6700));
        4: k = KW'($urandom_range(39900, 65535));
        default: k = KW'($urandom_range(K_MIN, K_MAX));
      endcase
      if (i == N_RANDOM * 4 / 5) begin
        while (kelvin_q.size() != 0) @(posedge clk);
        quiet = 1'b1;
      end
      kelvin_q.push_back(k);
    end
    stim_done = 1'b1;
  end

  initial begin
    wait (stim_done);
    while (!pipe_empty()) @(posedge clk);
    repeat (LATENCY + 20) @(posedge clk);
    if (errors == 0 && rgb_expected_q.size() == 0) begin
      $display("PASSED: all results match");
    end else begin
      $display("FAILED: results differ");
    end
    $finish;
  end

  initial begin
    wait (cycles >= LIMIT);
    $display("FAILED: results differ");
    $finish;
  end
endmodule
